[hdl/knob_set_countdown_timer_macros.svh]
// Assertion macros for the knob-set countdown timer.
`ifndef KNOB_SET_COUNTDOWN_TIMER_MACROS_SVH
`define KNOB_SET_COUNTDOWN_TIMER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is low.
`define KST_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("kst assertion failed");
// Next-cycle implication, disabled while reset is low.
`define KST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("kst assertion failed");
`else
`define KST_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define KST_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hdl/kst_pkg.sv]
// Types and constants shared by the knob-set countdown timer modules.
`default_nettype none
package kst_pkg;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    // register index, taken from paddr[3:2]
    localparam logic [1:0] REG_STEP_SECONDS     = 2'd0;
    localparam logic [1:0] REG_START_SECONDS    = 2'd1;
    localparam logic [1:0] REG_ALARM_REPEATS    = 2'd2;
    localparam logic [1:0] REG_TICKS_PER_SECOND = 2'd3;

    localparam logic [7:0]  RST_STEP_SECONDS     = 8'd10;
    localparam logic [15:0] RST_START_SECONDS    = 16'd10;
    localparam logic [7:0]  RST_ALARM_REPEATS    = 8'd1;
    localparam logic [15:0] RST_TICKS_PER_SECOND = 16'd1000;

    localparam logic [1:0] BEV_NONE    = 2'd0;
    localparam logic [1:0] BEV_PUSH    = 2'd1;
    localparam logic [1:0] BEV_RELEASE = 2'd2;

    localparam logic [1:0] TEV_NONE  = 2'd0;
    localparam logic [1:0] TEV_LEFT  = 2'd1;
    localparam logic [1:0] TEV_RIGHT = 2'd2;

    localparam logic ACT_PIN  = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef struct packed {
        logic action;
        logic enc_a;
        logic enc_b;
        logic button_level;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  button_event;
        logic [1:0]  turn_event;
        logic        pressed;
        logic        ring;
        logic [15:0] seconds_left;
        logic [15:0] seconds_top;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  step_seconds;
        logic [15:0] start_seconds;
        logic [7:0]  alarm_repeats;
        logic [15:0] ticks_per_second;
    } t_cfg;

endpackage
`default_nettype wire

[hdl/kst_cfg_regs.sv]
// APB register file holding the timer configuration.
`default_nettype none
module kst_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [kst_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [kst_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [kst_pkg::CFG_DATA_W-1:0] prdata,
    output kst_pkg::t_cfg                      o_cfg
);
    import kst_pkg::*;

    t_cfg       r_cfg;
    logic       w_wr;
    logic [1:0] w_idx;

    assign w_wr  = psel && penable && pwrite;
    assign w_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_seconds     <= RST_STEP_SECONDS;
            r_cfg.start_seconds    <= RST_START_SECONDS;
            r_cfg.alarm_repeats    <= RST_ALARM_REPEATS;
            r_cfg.ticks_per_second <= RST_TICKS_PER_SECOND;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_STEP_SECONDS:     r_cfg.step_seconds     <= pwdata[7:0];
                REG_START_SECONDS:    r_cfg.start_seconds    <= pwdata[15:0];
                REG_ALARM_REPEATS:    r_cfg.alarm_repeats    <= pwdata[7:0];
                REG_TICKS_PER_SECOND: r_cfg.ticks_per_second <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_STEP_SECONDS:     prdata = {24'd0, r_cfg.step_seconds};
            REG_START_SECONDS:    prdata = {16'd0, r_cfg.start_seconds};
            REG_ALARM_REPEATS:    prdata = {24'd0, r_cfg.alarm_repeats};
            REG_TICKS_PER_SECOND: prdata = {16'd0, r_cfg.ticks_per_second};
            default:              prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

[hdl/kst_core.sv]
// Timer state and the per-item decode, count and alarm logic.
`default_nettype none
module kst_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire kst_pkg::t_in_item i_item,
    input  wire kst_pkg::t_cfg     i_cfg,
    output kst_pkg::t_out_item     o_result
);
    import kst_pkg::*;

    logic [1:0]  r_last_single, n_last_single;
    logic [1:0]  r_last_rest,   n_last_rest;
    logic        r_last_button, n_last_button;
    logic [15:0] r_remaining,   n_remaining;
    logic [15:0] r_top,         n_top;
    logic [7:0]  r_rings,       n_rings;
    logic [15:0] r_ms,          n_ms;

    logic        w_pin;
    logic [1:0]  w_phase;
    logic        w_release;
    logic        w_push;
    logic [15:0] w_rem_base;
    logic [15:0] w_top_base;
    logic [16:0] w_sum;
    logic [15:0] w_rem_up;
    logic [15:0] w_rem_dn;
    logic [15:0] w_step;
    logic        w_detent;
    logic [15:0] w_ms_inc;
    logic        w_second;
    logic [1:0]  w_bev;
    logic [1:0]  w_tev;
    logic        w_ring;

    assign w_pin     = (i_item.action == ACT_PIN);
    assign w_phase   = {i_item.enc_b, i_item.enc_a};
    assign w_release = w_pin && i_item.button_level && !r_last_button;
    assign w_push    = w_pin && !i_item.button_level && r_last_button;

    // release loads the count before the detent of the same sample applies
    assign w_rem_base = w_release ? i_cfg.start_seconds : r_remaining;
    assign w_top_base = w_release ? i_cfg.start_seconds : r_top;
    assign w_step     = {8'd0, i_cfg.step_seconds};
    assign w_sum      = {1'b0, w_rem_base} + {1'b0, w_step};
    assign w_rem_up   = w_sum[16] ? 16'hFFFF : w_sum[15:0];
    assign w_rem_dn   = (w_rem_base >= w_step) ? (w_rem_base - w_step) : 16'd0;
    assign w_detent   = (w_phase == 2'd0) && (r_last_rest != 2'd0);

    assign w_ms_inc = (r_ms != 16'hFFFF) ? (r_ms + 16'd1) : r_ms;
    assign w_second = (w_ms_inc >= i_cfg.ticks_per_second);

    always_comb begin
        n_last_single = r_last_single;
        n_last_rest   = r_last_rest;
        n_last_button = r_last_button;
        n_remaining   = r_remaining;
        n_top         = r_top;
        n_rings       = r_rings;
        n_ms          = r_ms;
        w_bev         = BEV_NONE;
        w_tev         = TEV_NONE;
        w_ring        = 1'b0;
        if (!w_pin) begin
            n_ms = w_ms_inc;
            if (w_second) begin
                n_ms = 16'd0;
                if (r_remaining != 16'd0) begin
                    n_remaining = r_remaining - 16'd1;
                end else if (r_rings != 8'd0) begin
                    w_ring  = 1'b1;
                    n_rings = r_rings - 8'd1;
                end
            end
        end else begin
            n_last_button = i_item.button_level;
            n_remaining   = w_rem_base;
            n_top         = w_top_base;
            if (w_release) begin
                w_bev   = BEV_RELEASE;
                n_ms    = 16'd0;
                n_rings = i_cfg.alarm_repeats;
            end else if (w_push) begin
                w_bev = BEV_PUSH;
            end
            // rest phases are both-low and both-high; the rest are single-high
            if (w_phase == 2'd0 || w_phase == 2'd3) begin
                if (w_detent) begin
                    if (r_last_single[0]) begin
                        w_tev       = TEV_RIGHT;
                        n_remaining = w_rem_up;
                        if (w_rem_up > w_top_base) begin
                            n_top = w_rem_up;
                        end
                    end else begin
                        w_tev       = TEV_LEFT;
                        n_remaining = w_rem_dn;
                    end
                end
                n_last_rest = w_phase;
            end else begin
                n_last_single = w_phase;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_single <= 2'd0;
            r_last_rest   <= 2'd0;
            r_last_button <= 1'b0;
            r_remaining   <= 16'd0;
            r_top         <= 16'd0;
            r_rings       <= 8'd0;
            r_ms          <= 16'd0;
        end else if (i_en) begin
            r_last_single <= n_last_single;
            r_last_rest   <= n_last_rest;
            r_last_button <= n_last_button;
            r_remaining   <= n_remaining;
            r_top         <= n_top;
            r_rings       <= n_rings;
            r_ms          <= n_ms;
        end
    end

    always_comb begin
        o_result.button_event = w_bev;
        o_result.turn_event   = w_tev;
        o_result.pressed      = !n_last_button;
        o_result.ring         = w_ring;
        o_result.seconds_left = n_remaining;
        o_result.seconds_top  = n_top;
    end

endmodule
`default_nettype wire

[hdl/knob_set_countdown_timer.sv]
// Countdown timer set by a rotary encoder and push-button: top level.
//
// Input channel (i_in_valid / i_in_data / o_in_stall): each transfer is either
// a pin sample (encoder lines and button level) or a one millisecond tick.
// Output channel (o_out_valid / o_out_data / i_out_stall): exactly one result
// per input transfer, in order: button and detent events, pressed flag, alarm
// ring, seconds left and the top value for a progress display.
// Two register stages: the input register, then the state update and result
// register. An item passes from the input register through the state update
// into the result register, which holds it for the output transfer.
// Throughput is one item per cycle while the receiver does not stall; the state
// update is a single pass of compare and add logic.
// When the receiver stalls, the result register holds; the input register
// still takes one more item, after which o_in_stall rises until the result
// moves on.
// Configuration sits on the APB port: step_seconds at 0x0, start_seconds at
// 0x4, alarm_repeats at 0x8, ticks_per_second at 0xC. pready is tied high.
// Reset (synchronous, active low) empties both registers, clears the timer
// state and loads the register defaults (10, 10, 1, 1000).
`default_nettype none
`include "knob_set_countdown_timer_macros.svh"
module knob_set_countdown_timer (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    input  wire kst_pkg::t_in_item              i_in_data,
    output logic                                o_in_stall,
    output logic                                o_out_valid,
    output kst_pkg::t_out_item                  o_out_data,
    input  wire logic                           i_out_stall,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [kst_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [kst_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [kst_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                pready
);
    import kst_pkg::*;

    t_cfg      w_cfg;
    t_in_item  r_in;
    logic      r_in_valid;
    t_out_item r_out;
    logic      r_out_valid;
    t_out_item w_result;
    logic      w_advance;
    logic      w_in_take;
    logic      w_en;

    assign pready = 1'b1;

    kst_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (w_cfg)
    );

    // result register free or being drained this cycle
    assign w_advance  = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_in_take  = !o_in_stall;
    assign w_en       = r_in_valid && w_advance;

    kst_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_item   (r_in),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_take) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (w_en) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `KST_ASSERT_SAME(a_left_within_top, i_clk, i_rst_n, o_out_valid,
        o_out_data.seconds_left <= o_out_data.seconds_top)
    `KST_ASSERT_SAME(a_ring_only_on_tick, i_clk, i_rst_n, o_out_valid && o_out_data.ring,
        o_out_data.button_event == BEV_NONE && o_out_data.turn_event == TEV_NONE)
    `KST_ASSERT_SAME(a_event_matches_pressed, i_clk, i_rst_n,
        o_out_valid && o_out_data.button_event != BEV_NONE,
        o_out_data.pressed == (o_out_data.button_event == BEV_PUSH))
    `KST_ASSERT_NEXT(a_item_reaches_output, i_clk, i_rst_n, w_en, o_out_valid)

endmodule
`default_nettype wire

[dv/tb_knob_set_countdown_timer.sv]
// Testbench for the knob-set countdown timer: directed and random items checked by a predictor.
module tb_knob_set_countdown_timer;
    timeunit 1ns;
    timeprecision 1ps;

    import kst_pkg::*;

    localparam int STALL_LIMIT     = 3000;
    localparam int HOLD_OFF_CYCLES = 150;

    // quadrature phase codes, line A weight 1, line B weight 2
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_A    = 2'd1;
    localparam logic [1:0] PH_B    = 2'd2;
    localparam logic [1:0] PH_BOTH = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    t_in_item              i_in_data;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_item             o_out_data;
    logic                  i_out_stall;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    knob_set_countdown_timer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // predictor copy of the registers and timer state
    logic [7:0]  step_sec   = RST_STEP_SECONDS;
    logic [15:0] start_sec  = RST_START_SECONDS;
    logic [7:0]  alarm_reps = RST_ALARM_REPEATS;
    logic [15:0] tick_div   = RST_TICKS_PER_SECOND;
    logic [1:0]  single_phase = '0;
    logic [1:0]  rest_phase   = '0;
    logic        button_q     = 1'b0;
    logic [15:0] secs_left    = '0;
    logic [15:0] secs_top     = '0;
    logic [7:0]  rings_left   = '0;
    logic [15:0] ms_count     = '0;

    t_out_item pending_results[$];

    int  n_errors, n_in, n_out, n_ticks, n_rings, n_left, n_right, n_push, n_release, n_cfg;
    int  burst_left;
    bit  btn_now;
    bit  hold_off_req;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_out_item advance_timer(t_in_item it);
        t_out_item   r;
        logic [1:0]  phase;
        logic [16:0] sum;
        r = '0;
        if (it.action == ACT_TICK) begin
            if (ms_count != 16'hFFFF) ms_count = ms_count + 16'd1;
            if (ms_count >= tick_div) begin
                if (secs_left != 16'd0) begin
                    secs_left = secs_left - 16'd1;
                end else if (rings_left != 8'd0) begin
                    r.ring = 1'b1;
                    rings_left = rings_left - 8'd1;
                end
                ms_count = '0;
            end
        end else begin
            phase = {it.enc_b, it.enc_a};
            if (it.button_level != button_q) begin
                button_q = it.button_level;
                if (it.button_level) begin
                    r.button_event = BEV_RELEASE;
                    ms_count   = '0;
                    secs_left  = start_sec;
                    secs_top   = start_sec;
                    rings_left = alarm_reps;
                end else begin
                    r.button_event = BEV_PUSH;
                end
            end
            if (phase == PH_IDLE || phase == PH_BOTH) begin
                // detent completes on return to idle after a rest with both lines high
                if (phase == PH_IDLE && rest_phase != PH_IDLE) begin
                    if (single_phase[0]) begin
                        r.turn_event = TEV_RIGHT;
                        sum = {1'b0, secs_left} + step_sec;
                        secs_left = sum[16] ? 16'hFFFF : sum[15:0];
                        if (secs_left > secs_top) secs_top = secs_left;
                    end else begin
                        r.turn_event = TEV_LEFT;
                        secs_left = (secs_left >= step_sec) ? secs_left - step_sec : 16'd0;
                    end
                end
                rest_phase = phase;
            end else begin
                single_phase = phase;
            end
        end
        r.pressed      = !button_q;
        r.seconds_left = secs_left;
        r.seconds_top  = secs_top;
        return r;
    endfunction

    function automatic void compare_field(string name, int unsigned exp, int unsigned act);
        if (exp != act) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
            n_errors++;
        end
    endfunction

    // monitor: results are checked before new inputs are predicted at the same edge
    always @(posedge i_clk) begin
        t_out_item exp;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                n_out++;
                if (pending_results.size() == 0) begin
                    $display("%0t: result with nothing expected, actual %h", $time, o_out_data);
                    n_errors++;
                end else begin
                    exp = pending_results.pop_front();
                    compare_field("button_event", exp.button_event, o_out_data.button_event);
                    compare_field("turn_event", exp.turn_event, o_out_data.turn_event);
                    compare_field("pressed", exp.pressed, o_out_data.pressed);
                    compare_field("ring", exp.ring, o_out_data.ring);
                    compare_field("seconds_left", exp.seconds_left, o_out_data.seconds_left);
                    compare_field("seconds_top", exp.seconds_top, o_out_data.seconds_top);
                    n_rings   += exp.ring;
                    n_left    += (exp.turn_event == TEV_LEFT);
                    n_right   += (exp.turn_event == TEV_RIGHT);
                    n_push    += (exp.button_event == BEV_PUSH);
                    n_release += (exp.button_event == BEV_RELEASE);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                n_in++;
                n_ticks += (i_in_data.action == ACT_TICK);
                pending_results.push_back(advance_timer(i_in_data));
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || psel || (i_in_valid && !o_in_stall) ||
                (o_out_valid && !i_out_stall))
                idle = 0;
            else
                idle++;
        end
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, pending_results.size());
        $display("tb_knob_set_countdown_timer: errors");
        $finish;
    end

    // receiver stall: random segments of differing density, plus a long hold-off on request
    initial begin : out_stall_gen
        int seg_left, pct;
        seg_left = 0;
        pct = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                hold_off_req = 1'b0;
                i_out_stall <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(10, 80);
                    case ($urandom_range(0, 3))
                        0: pct = 0;
                        1: pct = 20;
                        2: pct = 50;
                        default: pct = 85;
                    endcase
                end
                seg_left--;
                i_out_stall <= ($urandom_range(0, 99) < pct);
            end
        end
    end

    function automatic t_in_item pin_sample(bit a, bit b, bit lvl);
        t_in_item it;
        it.action       = ACT_PIN;
        it.enc_a        = a;
        it.enc_b        = b;
        it.button_level = lvl;
        return it;
    endfunction

    // tick with random pin fields, which the block must ignore
    function automatic t_in_item ms_tick();
        t_in_item it;
        it = t_in_item'(4'($urandom_range(0, 7)));
        it.action = ACT_TICK;
        return it;
    endfunction

    // offer one item, hold it until the transfer, then maybe open a gap
    task automatic send_item(t_in_item it);
        int gap;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        if (it.action == ACT_PIN) btn_now = it.button_level;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
        end else begin
            burst_left--;
        end
    endtask

    // right detent passes B, both, A; left passes A, both, B; then both lines low
    task automatic send_detent(bit right, int n_phases);
        logic [1:0] seq [4];
        if (right) begin
            seq[0] = PH_B; seq[1] = PH_BOTH; seq[2] = PH_A; seq[3] = PH_IDLE;
        end else begin
            seq[0] = PH_A; seq[1] = PH_BOTH; seq[2] = PH_B; seq[3] = PH_IDLE;
        end
        for (int i = 0; i < n_phases; i++)
            send_item(pin_sample(seq[i][0], seq[i][1], btn_now));
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic apb_write_check(logic [1:0] idx, logic [31:0] val, logic [31:0] mask);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (pready) break;
        end
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (pready) break;
        end
        if ((prdata & mask) != (val & mask)) begin
            $display("%0t: register %0d readback, expected %0d, actual %0d",
                     $time, idx, val & mask, prdata & mask);
            n_errors++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic program_timer(logic [7:0] step, logic [15:0] start, logic [7:0] reps,
                                 logic [15:0] tps);
        wait_idle();
        apb_write_check(REG_STEP_SECONDS, 32'(step), 32'hFF);
        apb_write_check(REG_START_SECONDS, 32'(start), 32'hFFFF);
        apb_write_check(REG_ALARM_REPEATS, 32'(reps), 32'hFF);
        apb_write_check(REG_TICKS_PER_SECOND, 32'(tps), 32'hFFFF);
        step_sec   = step;
        start_sec  = start;
        alarm_reps = reps;
        tick_div   = tps;
        n_cfg++;
    endtask

    task automatic program_random_timer();
        logic [7:0]  step, reps;
        logic [15:0] start, tps;
        case ($urandom_range(0, 4))
            0: step = 8'd0;
            1: step = 8'd1;
            2: step = 8'd255;
            default: step = 8'($urandom_range(1, 30));
        endcase
        case ($urandom_range(0, 4))
            0: start = 16'd0;
            1: start = 16'hFFFF;
            2: start = 16'($urandom_range(0, 65535));
            default: start = 16'($urandom_range(0, 40));
        endcase
        case ($urandom_range(0, 3))
            0: reps = 8'd0;
            1: reps = 8'd255;
            default: reps = 8'($urandom_range(0, 5));
        endcase
        case ($urandom_range(0, 5))
            0: tps = 16'd0;
            1: tps = 16'd1;
            2: tps = 16'hFFFF;
            default: tps = 16'($urandom_range(1, 6));
        endcase
        program_timer(step, start, reps, tps);
    endtask

    // one unit of activity: mostly clean detents and tick runs, some noise and torn detents
    task automatic send_activity(output int n);
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 42) begin
            send_detent(1'($urandom_range(0, 1)), 4);
            n = 4;
        end else if (kind < 52) begin
            send_item(pin_sample(1'b0, 1'b0, !btn_now));
            n = 1;
        end else if (kind < 82) begin
            n = $urandom_range(1, 20);
            repeat (n) send_item(ms_tick());
        end else if (kind < 91) begin
            n = $urandom_range(1, 3);
            send_detent(1'($urandom_range(0, 1)), n);
        end else begin
            send_item(t_in_item'({ACT_PIN, 3'($urandom_range(0, 7))}));
            n = 1;
        end
    endtask

    task automatic send_activities(int count);
        int sent, n;
        sent = 0;
        while (sent < count) begin
            send_activity(n);
            sent += n;
        end
    endtask

    task automatic test_power_up();
        // tick before any sample, then the first released level loads the count
        send_item(ms_tick());
        send_item(pin_sample(1'b0, 1'b0, 1'b1));
    endtask

    task automatic test_detents();
        send_detent(1'b1, 4);
        send_detent(1'b0, 4);
    endtask

    task automatic test_count_limits();
        program_timer(8'd255, 16'd65530, RST_ALARM_REPEATS, RST_TICKS_PER_SECOND);
        send_item(pin_sample(1'b0, 1'b0, 1'b0));
        send_item(pin_sample(1'b0, 1'b0, 1'b1));
        send_detent(1'b1, 4);
    endtask

    task automatic test_alarm();
        // zero divider: every tick is a second; a left detent empties the count, then it rings twice
        program_timer(8'd255, 16'd3, 8'd2, 16'd0);
        send_item(pin_sample(1'b0, 1'b0, 1'b0));
        send_item(pin_sample(1'b0, 1'b0, 1'b1));
        send_detent(1'b0, 4);
        repeat (3) send_item(ms_tick());
    endtask

    task automatic test_backpressure();
        program_random_timer();
        hold_off_req = 1'b1;
        send_activities(60);
    endtask

    task automatic test_drain_pause();
        program_random_timer();
        send_activities(40);
        wait_idle();
        send_activities(40);
    endtask

    task automatic test_random_sessions();
        program_timer(8'd0, 16'hFFFF, 8'd255, 16'hFFFF);
        send_activities(110);
        program_timer(8'd1, 16'd0, 8'd0, 16'd1);
        send_activities(110);
        repeat (7) begin
            program_random_timer();
            send_activities(110);
        end
    endtask

    initial begin : run
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        hold_off_req = 1'b0;
        btn_now      = 1'b0;
        burst_left   = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_power_up();
        test_detents();
        test_count_limits();
        test_alarm();
        test_backpressure();
        test_drain_pause();
        test_random_sessions();

        wait_idle();
        repeat (8) @(posedge i_clk);
        $display("run covered %0d transfers in (%0d ticks), %0d results, %0d register settings",
                 n_in, n_ticks, n_out, n_cfg);
        $display("detents %0d left / %0d right, %0d pushes, %0d releases, %0d alarm rings",
                 n_left, n_right, n_push, n_release, n_rings);
        if (n_errors == 0)
            $display("tb_knob_set_countdown_timer: clean");
        else
            $display("tb_knob_set_countdown_timer: errors");
        $finish;
    end

endmodule
